@@ rtl/core/argon2_block_compression_core_assert.svh @@
// Assertion macros used by the block's checker module.
`ifndef ARGON2_BLOCK_COMPRESSION_CORE_ASSERT_SVH
`define ARGON2_BLOCK_COMPRESSION_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define A2_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion %m failed");

// Next-cycle implication checked outside reset.
`define A2_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion %m failed");

`endif

@@ rtl/core/a2c_pkg.sv @@
// Package: payload types, sequencer states and the GB schedule for the compression core.
`default_nettype none
package a2c_pkg;

    localparam int unsigned Words     = 128;
    localparam int unsigned AddrW     = 7;

    typedef struct packed {
        logic [63:0] x_word;
        logic [63:0] y_word;
    } in_item_t;

    typedef struct packed {
        logic [63:0] out_word_even;
        logic [63:0] out_word_odd;
        logic        last_pair;
    } out_item_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_RD_D,
        ST_CAP_D,
        ST_HALF1,
        ST_HALF2,
        ST_WR_A,
        ST_WR_B,
        ST_WR_C,
        ST_WR_D,
        ST_EMIT_RD,
        ST_EMIT_RD2,
        ST_EMIT_OUT
    } seq_state_t;

    // Control from sequencer to datapath
    typedef struct packed {
        logic             mem_we;
        logic [AddrW-1:0] mem_addr;
        logic [1:0]       cap_sel;
        logic             cap_en;
        logic             half1;
        logic             half2;
        logic [1:0]       wr_sel;
        logic             load;
    } ctl_t;

    function automatic logic [63:0] rotr(input logic [63:0] w, input int unsigned s);
        rotr = (w >> s) | (w << (64 - s));
    endfunction

    // Local index (0..15) of quad member m (0=a..3=d) of GB number g (0..7)
    function automatic logic [3:0] quad_idx(input logic [2:0] g, input logic [1:0] m);
        logic [3:0] base;
        base = {2'b00, g[1:0]};
        if (!g[2])
            quad_idx = base + {m, 2'b00};
        else
            unique case (m)
                2'd0: quad_idx = base;
                2'd1: quad_idx = 4'd4 + {2'b00, (g[1:0] + 2'd1)};
                2'd2: quad_idx = 4'd8 + {2'b00, (g[1:0] + 2'd2)};
                default: quad_idx = 4'd12 + {2'b00, (g[1:0] + 2'd3)};
            endcase
    endfunction

    // Map local index within row or column group to a word address
    function automatic logic [AddrW-1:0] word_addr(input logic col, input logic [2:0] grp,
                                                   input logic [3:0] li);
        if (!col)
            word_addr = {grp, li};
        else
            word_addr = {li[3:1], grp, li[0]};
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/a2c_gb_unit.sv @@
// GB datapath: four quad registers, two BlaMka half-rounds with registered products.
`default_nettype none
module a2c_gb_unit (
    input  wire logic            clk,
    input  wire a2c_pkg::ctl_t   ctl,
    input  wire logic [63:0]     rd_data,
    output logic [63:0]          wr_data
);
    logic [63:0] a_reg, b_reg, c_reg, d_reg;
    logic [63:0] a_next, b_next, c_next, d_next;
    logic [1:0]  step_reg, step_next;
    logic [63:0] prod_reg, prod_next;

    // One half-round phase: ST_HALF1 forms product, ST_HALF2 finishes add+rotate.
    // step counts four sub-steps a,c,a,c per GB.
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        d_next    = d_reg;
        step_next = step_reg;
        prod_next = prod_reg;
        if (ctl.cap_en)
        begin
            unique case (ctl.cap_sel)
                2'd0: a_next = rd_data;
                2'd1: b_next = rd_data;
                2'd2: c_next = rd_data;
                default: d_next = rd_data;
            endcase
            step_next = 2'd0;
        end
        else if (ctl.half1)
        begin
            if (!step_reg[0])
                prod_next = {32'd0, a_reg[31:0]} * {32'd0, b_reg[31:0]};
            else
                prod_next = {32'd0, c_reg[31:0]} * {32'd0, d_reg[31:0]};
        end
        else if (ctl.half2)
        begin
            if (!step_reg[0])
            begin
                a_next = a_reg + b_reg + {prod_reg[62:0], 1'b0};
                d_next = a2c_pkg::rotr(d_reg ^ a_next, step_reg[1] ? 16 : 32);
            end
            else
            begin
                c_next = c_reg + d_reg + {prod_reg[62:0], 1'b0};
                b_next = a2c_pkg::rotr(b_reg ^ c_next, step_reg[1] ? 63 : 24);
            end
            step_next = step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        step_reg <= step_next;
        prod_reg <= prod_next;
    end

    always_comb
    begin
        unique case (ctl.wr_sel)
            2'd0: wr_data = a_reg;
            2'd1: wr_data = b_reg;
            2'd2: wr_data = c_reg;
            default: wr_data = d_reg;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/core/a2c_seq.sv @@
// Sequencer: load, row/column GB schedule and emit over the word memories.
`default_nettype none
module a2c_seq (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic                 out_last,
    output a2c_pkg::ctl_t        ctl,
    output logic                 emit_cap_even
);
    a2c_pkg::seq_state_t state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;    // load position or emit pair
    logic       col_reg, col_next;    // column pass
    logic [2:0] grp_reg, grp_next;    // row or column group
    logic [2:0] gb_reg, gb_next;      // GB within P
    logic [1:0] hcnt_reg, hcnt_next;  // half-round counter

    logic [6:0] qaddr [4];

    always_comb
    begin
        for (int m = 0; m < 4; m++)
            qaddr[m] = a2c_pkg::word_addr(col_reg, grp_reg,
                                          a2c_pkg::quad_idx(gb_reg, m[1:0]));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        col_next   = col_reg;
        grp_next   = grp_reg;
        gb_next    = gb_reg;
        hcnt_next  = hcnt_reg;
        unique case (state_reg)
            a2c_pkg::ST_LOAD:
                if (in_valid)
                begin
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd127)
                    begin
                        state_next = a2c_pkg::ST_RD_A;
                        col_next = 1'b0; grp_next = 3'd0; gb_next = 3'd0;
                    end
                end
            a2c_pkg::ST_RD_A: state_next = a2c_pkg::ST_RD_B;
            a2c_pkg::ST_RD_B: state_next = a2c_pkg::ST_RD_C;
            a2c_pkg::ST_RD_C: state_next = a2c_pkg::ST_RD_D;
            a2c_pkg::ST_RD_D: state_next = a2c_pkg::ST_CAP_D;
            a2c_pkg::ST_CAP_D:
            begin
                state_next = a2c_pkg::ST_HALF1;
                hcnt_next = 2'd0;
            end
            a2c_pkg::ST_HALF1: state_next = a2c_pkg::ST_HALF2;
            a2c_pkg::ST_HALF2:
            begin
                hcnt_next = hcnt_reg + 2'd1;
                state_next = (hcnt_reg == 2'd3) ? a2c_pkg::ST_WR_A : a2c_pkg::ST_HALF1;
            end
            a2c_pkg::ST_WR_A: state_next = a2c_pkg::ST_WR_B;
            a2c_pkg::ST_WR_B: state_next = a2c_pkg::ST_WR_C;
            a2c_pkg::ST_WR_C: state_next = a2c_pkg::ST_WR_D;
            a2c_pkg::ST_WR_D:
            begin
                state_next = a2c_pkg::ST_RD_A;
                gb_next = gb_reg + 3'd1;
                if (gb_reg == 3'd7)
                begin
                    grp_next = grp_reg + 3'd1;
                    if (grp_reg == 3'd7)
                    begin
                        col_next = 1'b1;
                        if (col_reg)
                        begin
                            state_next = a2c_pkg::ST_EMIT_RD;
                            cnt_next = 7'd0;
                        end
                    end
                end
            end
            a2c_pkg::ST_EMIT_RD:  state_next = a2c_pkg::ST_EMIT_RD2;
            a2c_pkg::ST_EMIT_RD2: state_next = a2c_pkg::ST_EMIT_OUT;
            a2c_pkg::ST_EMIT_OUT:
                if (out_ready)
                begin
                    cnt_next = cnt_reg + 7'd1;
                    state_next = (cnt_reg == 7'd63) ? a2c_pkg::ST_LOAD : a2c_pkg::ST_EMIT_RD;
                    if (cnt_reg == 7'd63)
                        cnt_next = 7'd0;
                end
            default: state_next = a2c_pkg::ST_LOAD;
        endcase
    end

    // Outputs
    always_comb
    begin
        ctl = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        out_last = (cnt_reg == 7'd63);
        emit_cap_even = 1'b0;
        unique case (state_reg)
            a2c_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                ctl.load = 1'b1;
                ctl.mem_addr = cnt_reg;
                ctl.mem_we = in_valid;
            end
            a2c_pkg::ST_RD_A: ctl.mem_addr = qaddr[0];
            a2c_pkg::ST_RD_B:
            begin
                ctl.mem_addr = qaddr[1];
                ctl.cap_en = 1'b1; ctl.cap_sel = 2'd0;
            end
            a2c_pkg::ST_RD_C:
            begin
                ctl.mem_addr = qaddr[2];
                ctl.cap_en = 1'b1; ctl.cap_sel = 2'd1;
            end
            a2c_pkg::ST_RD_D:
            begin
                ctl.mem_addr = qaddr[3];
                ctl.cap_en = 1'b1; ctl.cap_sel = 2'd2;
            end
            // d word arrives in the cycle after its read
            a2c_pkg::ST_CAP_D:
            begin
                ctl.cap_en = 1'b1; ctl.cap_sel = 2'd3;
            end
            a2c_pkg::ST_HALF1: ctl.half1 = 1'b1;
            a2c_pkg::ST_HALF2: ctl.half2 = 1'b1;
            a2c_pkg::ST_WR_A:
            begin
                ctl.mem_we = 1'b1; ctl.mem_addr = qaddr[0]; ctl.wr_sel = 2'd0;
            end
            a2c_pkg::ST_WR_B:
            begin
                ctl.mem_we = 1'b1; ctl.mem_addr = qaddr[1]; ctl.wr_sel = 2'd1;
            end
            a2c_pkg::ST_WR_C:
            begin
                ctl.mem_we = 1'b1; ctl.mem_addr = qaddr[2]; ctl.wr_sel = 2'd2;
            end
            a2c_pkg::ST_WR_D:
            begin
                ctl.mem_we = 1'b1; ctl.mem_addr = qaddr[3]; ctl.wr_sel = 2'd3;
            end
            a2c_pkg::ST_EMIT_RD: ctl.mem_addr = {cnt_reg[5:0], 1'b0};
            a2c_pkg::ST_EMIT_RD2:
            begin
                ctl.mem_addr = {cnt_reg[5:0], 1'b1};
                emit_cap_even = 1'b1;
            end
            // keep rereading the odd word so it holds while the transaction waits
            a2c_pkg::ST_EMIT_OUT:
            begin
                out_valid = 1'b1;
                ctl.mem_addr = {cnt_reg[5:0], 1'b1};
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= a2c_pkg::ST_LOAD;
            cnt_reg   <= '0;
            col_reg   <= 1'b0;
            grp_reg   <= '0;
            gb_reg    <= '0;
            hcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            col_reg   <= col_next;
            grp_reg   <= grp_next;
            gb_reg    <= gb_next;
            hcnt_reg  <= hcnt_next;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/argon2_block_compression_core.sv @@
// Top level of the Argon2 compression core G.
// Takes 128 input transactions (word i of X and Y) per block, then runs the BlaMka
// permutation over the stored block and returns 64 output transactions of two words,
// the last flagged. Input words are accepted one per cycle; the compression then
// runs 128 GB steps of 4 reads, 1 capture, the half-round phases and 4 writes,
// bound by the single port of the working memory, and emitting reads both words of
// each pair before offering it and holds the pair until it is taken. Inputs are not
// taken while a block is being compressed or emitted.
`default_nettype none
module argon2_block_compression_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire a2c_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output a2c_pkg::out_item_t     out_data
);
    a2c_pkg::ctl_t ctl;
    logic          emit_cap_even, out_last;
    logic [63:0]   gb_wr;
    logic [63:0]   work_mem [a2c_pkg::Words];
    logic [63:0]   xor_mem  [a2c_pkg::Words];
    logic [63:0]   work_rd_reg, xor_rd_reg;
    logic [63:0]   even_reg, even_next;
    logic [63:0]   load_word;

    a2c_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_last     (out_last),
        .ctl          (ctl),
        .emit_cap_even(emit_cap_even)
    );

    a2c_gb_unit u_gb (
        .clk    (clk),
        .ctl    (ctl),
        .rd_data(work_rd_reg),
        .wr_data(gb_wr)
    );

    assign load_word = in_data.x_word ^ in_data.y_word;

    // Working and xor memories, one port each
    always_ff @(posedge clk)
    begin
        if (ctl.mem_we)
            work_mem[ctl.mem_addr] <= ctl.load ? load_word : gb_wr;
        work_rd_reg <= work_mem[ctl.mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mem_we && ctl.load)
            xor_mem[ctl.mem_addr] <= load_word;
        xor_rd_reg <= xor_mem[ctl.mem_addr];
    end

    assign even_next = emit_cap_even ? (work_rd_reg ^ xor_rd_reg) : even_reg;
    always_ff @(posedge clk)
    begin
        even_reg <= even_next;
    end

    // Odd word comes straight from the read registers, held by rereading its address
    assign out_data.out_word_even = even_reg;
    assign out_data.out_word_odd  = work_rd_reg ^ xor_rd_reg;
    assign out_data.last_pair     = out_last;
endmodule
`default_nettype wire

@@ rtl/core/a2c_checker.sv @@
// Port-level checker for the compression core, bound to the top level.
`default_nettype none
`include "argon2_block_compression_core_assert.svh"
module a2c_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire a2c_pkg::out_item_t out_data
);
    `A2_ASSERT_IMPL(no_in_while_out, clk, rst_n, out_valid, !in_ready)
    `A2_ASSERT_NEXT(in_hold, clk, rst_n, in_valid && !in_ready, in_valid)
    `A2_ASSERT_NEXT(out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    `A2_ASSERT_NEXT(last_ends_block, clk, rst_n, out_valid && out_ready && out_data.last_pair, !out_valid)
endmodule

bind argon2_block_compression_core a2c_checker u_a2c_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
);
`default_nettype wire
